/* rtl/core/timecode_frame_advance_biphase_macros.svh */
// Assertion macros used by the checker file of the time code block.
`ifndef TIMECODE_FRAME_ADVANCE_BIPHASE_MACROS_SVH
`define TIMECODE_FRAME_ADVANCE_BIPHASE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCFAB_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timecode block assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TCFAB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timecode block assertion failed");

`endif

/* rtl/core/tcfab_pkg.sv */
// Package with the types, constants and functions of the time code advance and encoder.
package tcfab_pkg;

	localparam int unsigned WordW = 64;
	localparam int unsigned AddrW = 5;
	localparam int unsigned NumNibbles = 20;
	localparam int unsigned NibVecW = 4 * NumNibbles;
	localparam logic [AddrW-1:0] LastAddr = AddrW'(NumNibbles - 1);
	localparam logic [7:0] SyncLo = 8'hfc;
	localparam logic [7:0] SyncHi = 8'hbf;

	typedef struct packed {
		logic [3:0] u;
		logic [1:0] t;
		logic carry;
	} frame_res_t;

	typedef struct packed {
		logic [3:0] u;
		logic [2:0] t;
		logic carry;
	} bcd60_t;

	typedef struct packed {
		logic [3:0] u;
		logic [1:0] t;
	} hour_res_t;

	function automatic frame_res_t frame_step(logic [3:0] u, logic [1:0] t, logic sys625);
		frame_res_t r;
		logic [2:0] t1;
		t1 = {1'b0, t} + 3'd1;
		r.u = u + 4'd1;
		r.t = t;
		r.carry = 1'b0;
		if (sys625) begin
			if (t >= 2'd2 && u >= 4'd4) begin
				r.u = 4'd0;
				r.t = 2'd0;
				r.carry = 1'b1;
			end else if (u == 4'd9) begin
				r.u = 4'd0;
				r.t = t1[1:0];
			end
		end else begin
			if (u == 4'd9) begin
				r.u = 4'd0;
				if (t1 >= 3'd3) begin
					r.t = 2'd0;
					r.carry = 1'b1;
				end else begin
					r.t = t1[1:0];
				end
			end
		end
		return r;
	endfunction

	function automatic bcd60_t step60(logic [3:0] u, logic [2:0] t);
		bcd60_t r;
		logic [3:0] t1;
		t1 = {1'b0, t} + 4'd1;
		r.u = u + 4'd1;
		r.t = t;
		r.carry = 1'b0;
		if (u == 4'd9) begin
			r.u = 4'd0;
			if (t1 >= 4'd6) begin
				r.t = 3'd0;
				r.carry = 1'b1;
			end else begin
				r.t = t1[2:0];
			end
		end
		return r;
	endfunction

	function automatic hour_res_t hour_step(logic [3:0] u, logic [1:0] t);
		hour_res_t r;
		r.u = u + 4'd1;
		r.t = t;
		if (t >= 2'd2 && u >= 4'd3) begin
			r.u = 4'd0;
			r.t = 2'd0;
		end else if (u == 4'd9) begin
			r.u = 4'd0;
			r.t = t + 2'd1;
		end
		return r;
	endfunction

	// Each byte is bit-reversed and split high nibble first; nibble 0 sits at the bottom.
	function automatic logic [NibVecW-1:0] pack_nibbles(logic [WordW-1:0] w);
		logic [NibVecW-1:0] r;
		logic [7:0] v;
		r = '0;
		for (int i = 0; i < NumNibbles / 2; i++) begin
			if (i < 8) begin
				v = w[8*i +: 8];
			end else if (i == 8) begin
				v = SyncLo;
			end else begin
				v = SyncHi;
			end
			r[8*i +: 4] = {v[0], v[1], v[2], v[3]};
			r[8*i+4 +: 4] = {v[4], v[5], v[6], v[7]};
		end
		return r;
	endfunction

	function automatic logic [7:0] biphase_code(logic [3:0] nib);
		logic [7:0] e;
		unique case (nib)
			4'h0: e = 8'hcc;
			4'h1: e = 8'hcd;
			4'h2: e = 8'hcb;
			4'h3: e = 8'hca;
			4'h4: e = 8'hd3;
			4'h5: e = 8'hd2;
			4'h6: e = 8'hd4;
			4'h7: e = 8'hd5;
			4'h8: e = 8'hb3;
			4'h9: e = 8'hb2;
			4'ha: e = 8'hb4;
			4'hb: e = 8'hb5;
			4'hc: e = 8'hac;
			4'hd: e = 8'had;
			4'he: e = 8'hab;
			4'hf: e = 8'haa;
		endcase
		return e;
	endfunction

endpackage

/* rtl/core/tcfab_in_if.sv */
// Stream interface that carries one time code word per handshake.
interface tcfab_in_if
	import tcfab_pkg::*;
();
	logic valid;
	logic ready;
	logic [WordW-1:0] timecode_words;

	modport source(output valid, output timecode_words, input ready);
	modport sink(input valid, input timecode_words, output ready);
endinterface

/* rtl/core/tcfab_out_if.sv */
// Stream interface that carries one encoded RAM byte and its address per handshake.
interface tcfab_out_if
	import tcfab_pkg::*;
();
	logic valid;
	logic ready;
	logic [AddrW-1:0] ram_address;
	logic [7:0] ram_byte;
	logic last_byte;

	modport source(output valid, output ram_address, output ram_byte, output last_byte,
		input ready);
	modport sink(input valid, input ram_address, input ram_byte, input last_byte,
		output ready);
endinterface

/* rtl/core/tcfab_cfg_if.sv */
// Write channel for the frame system configuration register.
interface tcfab_cfg_if;
	logic valid;
	logic ready;
	logic frame_system_625;

	modport source(output valid, output frame_system_625, input ready);
	modport sink(input valid, input frame_system_625, output ready);
endinterface

/* rtl/core/timecode_frame_advance_biphase.sv */
// Top level of the time code frame advance and bi-phase encoder.
//
//   channel    dir   payload                                  handshake
//   cfg        in    frame_system_625                         valid/ready, ready always high
//   timecode   in    timecode_words[63:0]                     valid/ready
//   ram        out   ram_address[4:0], ram_byte, last_byte    valid/ready
//
// Each word yields twenty output words, one per cycle while the output is not stalled;
// the single output port, which moves one byte per handshake, limits the throughput.
// An accepted input word passes through stages s1, s2 and s3 and the emitter to the output register.
// Reset clears all valid bits and sets the 25 frame system.
// A stall on the output holds the output register and backs up through the stages
// without loss; three further words can be taken while one is being encoded.
module timecode_frame_advance_biphase
	import tcfab_pkg::*;
(
	input logic clk,
	input logic arst_n,
	tcfab_cfg_if.sink cfg,
	tcfab_in_if.sink timecode,
	tcfab_out_if.source ram
);

	logic sys625_q;

	logic valid_s1;
	logic [WordW-1:0] word_s1;
	frame_res_t frame_s1;
	bcd60_t sec_s1;
	bcd60_t min_s1;
	hour_res_t hour_s1;

	logic valid_s2;
	logic [WordW-1:0] word_s2;
	logic parity_s2;

	logic valid_s3;
	logic [NibVecW-1:0] nib_s3;

	logic em_busy_q;
	logic [AddrW-1:0] em_cnt_q;
	logic em_pol_q;
	logic [NibVecW-1:0] em_data_q;

	logic out_valid_q;
	logic [AddrW-1:0] out_addr_q;
	logic [7:0] out_byte_q;
	logic out_last_q;

	logic out_en;
	logic em_load;
	logic adv_s1;
	logic adv_s2;
	logic adv_s3;
	logic [7:0] enc;
	logic [WordW-1:0] merged;
	logic [WordW-1:0] fixed;

	assign cfg.ready = 1'b1;

	assign out_en = !out_valid_q || ram.ready;
	assign em_load = valid_s3 && (!em_busy_q || (out_en && em_cnt_q == LastAddr));
	assign adv_s3 = !valid_s3 || em_load;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign timecode.ready = adv_s1;

	always_comb begin
		merged = word_s1;
		merged[3:0] = frame_s1.u;
		merged[9:8] = frame_s1.t;
		if (frame_s1.carry) begin
			merged[19:16] = sec_s1.u;
			merged[26:24] = sec_s1.t;
			if (sec_s1.carry) begin
				merged[35:32] = min_s1.u;
				merged[42:40] = min_s1.t;
				if (min_s1.carry) begin
					merged[51:48] = hour_s1.u;
					merged[57:56] = hour_s1.t;
				end
			end
		end
	end

	always_comb begin
		fixed = word_s2;
		if (!parity_s2) begin
			if (sys625_q) begin
				fixed[59] = ~word_s2[59];
			end else begin
				fixed[27] = ~word_s2[27];
			end
		end
	end

	assign enc = em_pol_q ? ~biphase_code(em_data_q[3:0]) : biphase_code(em_data_q[3:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sys625_q <= 1'b1;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			em_busy_q <= 1'b0;
			em_cnt_q <= '0;
			em_pol_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				sys625_q <= cfg.frame_system_625;
			end
			if (adv_s1) begin
				valid_s1 <= timecode.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
			if (out_en) begin
				out_valid_q <= em_busy_q;
			end
			if (em_load) begin
				em_busy_q <= 1'b1;
				em_cnt_q <= '0;
				em_pol_q <= 1'b0;
			end else if (out_en && em_busy_q) begin
				em_cnt_q <= em_cnt_q + AddrW'(1);
				em_pol_q <= enc[0];
				if (em_cnt_q == LastAddr) begin
					em_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			word_s1 <= timecode.timecode_words;
			frame_s1 <= frame_step(timecode.timecode_words[3:0],
				timecode.timecode_words[9:8], sys625_q);
			sec_s1 <= step60(timecode.timecode_words[19:16], timecode.timecode_words[26:24]);
			min_s1 <= step60(timecode.timecode_words[35:32], timecode.timecode_words[42:40]);
			hour_s1 <= hour_step(timecode.timecode_words[51:48],
				timecode.timecode_words[57:56]);
		end
		if (adv_s2) begin
			word_s2 <= merged;
			parity_s2 <= ^merged;
		end
		if (adv_s3) begin
			nib_s3 <= pack_nibbles(fixed);
		end
		if (out_en && em_busy_q) begin
			out_addr_q <= em_cnt_q;
			out_byte_q <= enc;
			out_last_q <= (em_cnt_q == LastAddr);
		end
		if (em_load) begin
			em_data_q <= nib_s3;
		end else if (out_en && em_busy_q) begin
			em_data_q <= em_data_q >> 4;
		end
	end

	assign ram.valid = out_valid_q;
	assign ram.ram_address = out_addr_q;
	assign ram.ram_byte = out_byte_q;
	assign ram.last_byte = out_last_q;

endmodule

/* rtl/core/tcfab_checker.sv */
// Port checker for the time code encoder and the bind that attaches it.
`include "timecode_frame_advance_biphase_macros.svh"

module tcfab_checker
	import tcfab_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [AddrW-1:0] out_addr,
	input logic [7:0] out_byte,
	input logic out_last
);

	logic [AddrW-1:0] exp_addr_q;
	logic [2:0] pending_q;
	logic in_fire;
	logic out_fire;
	logic out_done;

	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign out_done = out_fire && out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_addr_q <= '0;
			pending_q <= '0;
		end else begin
			if (out_fire) begin
				exp_addr_q <= out_last ? '0 : out_addr + AddrW'(1);
			end
			if (in_fire && !out_done) begin
				pending_q <= pending_q + 3'd1;
			end else if (!in_fire && out_done && pending_q != 3'd0) begin
				pending_q <= pending_q - 3'd1;
			end
		end
	end

	`TCFAB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(out_addr) && $stable(out_byte) && $stable(out_last))
	`TCFAB_ASSERT_SAME(a_last_at_end, out_valid, out_last == (out_addr == LastAddr))
	`TCFAB_ASSERT_SAME(a_addr_in_order, out_valid, out_addr == exp_addr_q)
	`TCFAB_ASSERT_SAME(a_out_has_source, out_valid, pending_q != 3'd0)

endmodule

bind timecode_frame_advance_biphase tcfab_checker u_tcfab_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(timecode.valid),
	.in_ready(timecode.ready),
	.out_valid(ram.valid),
	.out_ready(ram.ready),
	.out_addr(ram.ram_address),
	.out_byte(ram.ram_byte),
	.out_last(ram.last_byte)
);

/* test/timecode_frame_advance_biphase_tb.sv */
// Self-checking testbench for the time code frame advance and bi-phase encoder.
module timecode_frame_advance_biphase_tb;
	import tcfab_pkg::*;

	localparam int unsigned HoldCycles = 300;
	localparam int unsigned StallLimit = 3000;
	localparam int unsigned SettleCycles = 12;
	localparam logic [WordW-1:0] TimeMask = 64'h030F_070F_070F_030F;

	typedef struct packed {
		logic [AddrW-1:0] addr;
		logic [7:0] code;
		logic last;
	} ram_word_t;

	class biphase_ram_book;
		logic sys625 = 1'b1;
		ram_word_t pending[$];
		int errors = 0;
		int words_25 = 0;
		int words_30 = 0;
		int ram_words_seen = 0;

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		function void step_sixty(inout logic [3:0] u, inout logic [2:0] t, inout logic carry);
			logic [3:0] t_next;
			if (!carry) begin
				return;
			end
			if (u == 4'd9) begin
				u = 4'd0;
				t_next = {1'b0, t} + 4'd1;
				if (t_next >= 4'd6) begin
					t = 3'd0;
				end else begin
					t = t_next[2:0];
					carry = 1'b0;
				end
			end else begin
				u = u + 4'd1;
				carry = 1'b0;
			end
		endfunction

		function logic [WordW-1:0] advance_one_frame(logic [WordW-1:0] w);
			logic [3:0] fu, su, mu, hu;
			logic [1:0] ft, ht;
			logic [2:0] st, mt, ft_next;
			logic carry;
			logic [WordW-1:0] r;
			fu = w[3:0];
			ft = w[9:8];
			su = w[19:16];
			st = w[26:24];
			mu = w[35:32];
			mt = w[42:40];
			hu = w[51:48];
			ht = w[57:56];
			carry = 1'b0;
			if (sys625) begin
				if (ft >= 2'd2 && fu >= 4'd4) begin
					fu = 4'd0;
					ft = 2'd0;
					carry = 1'b1;
				end else if (fu == 4'd9) begin
					fu = 4'd0;
					ft = ft + 2'd1;
				end else begin
					fu = fu + 4'd1;
				end
			end else begin
				if (fu == 4'd9) begin
					fu = 4'd0;
					ft_next = {1'b0, ft} + 3'd1;
					if (ft_next >= 3'd3) begin
						ft = 2'd0;
						carry = 1'b1;
					end else begin
						ft = ft_next[1:0];
					end
				end else begin
					fu = fu + 4'd1;
				end
			end
			step_sixty(su, st, carry);
			step_sixty(mu, mt, carry);
			if (carry) begin
				if (ht >= 2'd2 && hu >= 4'd3) begin
					hu = 4'd0;
					ht = 2'd0;
				end else if (hu == 4'd9) begin
					hu = 4'd0;
					ht = ht + 2'd1;
				end else begin
					hu = hu + 4'd1;
				end
			end
			r = w;
			r[3:0] = fu;
			r[9:8] = ft;
			r[19:16] = su;
			r[26:24] = st;
			r[35:32] = mu;
			r[42:40] = mt;
			r[51:48] = hu;
			r[57:56] = ht;
			return r;
		endfunction

		function void note_timecode(logic [WordW-1:0] w);
			logic [WordW-1:0] adv;
			logic [7:0] v, rv, e;
			logic [3:0] nib;
			logic pol;
			ram_word_t rw;
			adv = advance_one_frame(w);
			if (^adv == 1'b0) begin
				if (sys625) begin
					adv[59] = ~adv[59];
				end else begin
					adv[27] = ~adv[27];
				end
			end
			if (sys625) begin
				words_25++;
			end else begin
				words_30++;
			end
			pol = 1'b0;
			for (int i = 0; i < 10; i++) begin
				v = (i < 8) ? adv[8*i +: 8] : ((i == 8) ? SyncLo : SyncHi);
				for (int j = 0; j < 8; j++) begin
					rv[j] = v[7-j];
				end
				for (int h = 0; h < 2; h++) begin
					nib = (h == 0) ? rv[7:4] : rv[3:0];
					case (nib)
						4'h0: e = 8'hcc;
						4'h1: e = 8'hcd;
						4'h2: e = 8'hcb;
						4'h3: e = 8'hca;
						4'h4: e = 8'hd3;
						4'h5: e = 8'hd2;
						4'h6: e = 8'hd4;
						4'h7: e = 8'hd5;
						4'h8: e = 8'hb3;
						4'h9: e = 8'hb2;
						4'ha: e = 8'hb4;
						4'hb: e = 8'hb5;
						4'hc: e = 8'hac;
						4'hd: e = 8'had;
						4'he: e = 8'hab;
						default: e = 8'haa;
					endcase
					if (pol) begin
						e = ~e;
					end
					pol = e[0];
					rw.addr = AddrW'(2 * i + h);
					rw.code = e;
					rw.last = (rw.addr == LastAddr);
					pending.push_back(rw);
				end
			end
		endfunction

		task check_ram_word(logic [AddrW-1:0] addr, logic [7:0] code, logic last);
			ram_word_t want;
			ram_words_seen++;
			if (pending.size() == 0) begin
				report($sformatf("unexpected RAM word addr %0d byte %02h", addr, code));
				return;
			end
			want = pending.pop_front();
			if (addr !== want.addr) begin
				report($sformatf("ram_address %0d, expected %0d", addr, want.addr));
			end
			if (code !== want.code) begin
				report($sformatf("ram_byte %02h at addr %0d, expected %02h", code, want.addr,
					want.code));
			end
			if (last !== want.last) begin
				report($sformatf("last_byte %b at addr %0d, expected %b", last, want.addr,
					want.last));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int src_idle_pct;
	int sink_idle_pct;
	bit hold_req;
	int unsigned stall_count;
	biphase_ram_book book;

	tcfab_cfg_if cfg_if();
	tcfab_in_if timecode_if();
	tcfab_out_if ram_if();

	timecode_frame_advance_biphase dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.timecode(timecode_if),
		.ram(ram_if)
	);

	always #2 clk = ~clk;

	function automatic logic [WordW-1:0] pack_time(int hh, int mm, int ss, int ff,
		logic [WordW-1:0] extra);
		logic [WordW-1:0] w;
		w = extra & ~TimeMask;
		w[3:0] = 4'(ff % 10);
		w[9:8] = 2'(ff / 10);
		w[19:16] = 4'(ss % 10);
		w[26:24] = 3'(ss / 10);
		w[35:32] = 4'(mm % 10);
		w[42:40] = 3'(mm / 10);
		w[51:48] = 4'(hh % 10);
		w[57:56] = 2'(hh / 10);
		return w;
	endfunction

	function automatic logic [WordW-1:0] random_timecode(logic sys);
		int frames, hh, mm, ss, ff;
		logic [WordW-1:0] extra;
		frames = sys ? 25 : 30;
		extra = {$urandom, $urandom};
		if ($urandom_range(9) < 3) begin
			return extra;
		end
		ff = ($urandom_range(2) == 0) ? frames - 1 : $urandom_range(frames - 1);
		ss = ($urandom_range(2) == 0) ? 59 : $urandom_range(59);
		mm = ($urandom_range(2) == 0) ? 59 : $urandom_range(59);
		hh = ($urandom_range(2) == 0) ? 23 : $urandom_range(23);
		if ($urandom_range(9) == 0) begin
			hh = $urandom_range(39, 24);
		end
		return pack_time(hh, mm, ss, ff, extra);
	endfunction

	task automatic send_word(input logic [WordW-1:0] w);
		while ($urandom_range(99) < src_idle_pct) begin
			timecode_if.valid = 1'b0;
			@(negedge clk);
		end
		timecode_if.valid = 1'b1;
		timecode_if.timecode_words = w;
		do @(posedge clk); while (!timecode_if.ready);
		book.note_timecode(w);
		@(negedge clk);
	endtask

	task automatic write_frame_system(input logic sys);
		cfg_if.valid = 1'b1;
		cfg_if.frame_system_625 = sys;
		do @(posedge clk); while (!cfg_if.ready);
		book.sys625 = sys;
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic drain_results();
		timecode_if.valid = 1'b0;
		while (book.pending.size() != 0) begin
			@(negedge clk);
		end
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic random_phase(input int count, input logic sys);
		write_frame_system(sys);
		for (int n = 0; n < count; n++) begin
			send_word(random_timecode(sys));
		end
		drain_results();
	endtask

	initial begin
		ram_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				ram_if.ready = 1'b0;
				repeat (HoldCycles - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				ram_if.ready = ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && ram_if.valid && ram_if.ready) begin
			book.check_ram_word(ram_if.ram_address, ram_if.ram_byte, ram_if.last_byte);
		end
	end

	always @(posedge clk) begin
		if ((timecode_if.valid && timecode_if.ready) || (ram_if.valid && ram_if.ready) ||
			(cfg_if.valid && cfg_if.ready)) begin
			stall_count <= 0;
		end else if (stall_count >= StallLimit) begin
			$display("Watchdog: no word moved for %0d cycles", StallLimit);
			$display("TEST FAILED");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

	initial begin
		book = new();
		stall_count = 0;
		hold_req = 1'b0;
		src_idle_pct = 32;
		sink_idle_pct = 67;
		arst_n = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.frame_system_625 = 1'b0;
		timecode_if.valid = 1'b0;
		timecode_if.timecode_words = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_frame_system(1'b1);
		send_word(pack_time(0, 0, 0, 0, 64'h0));
		send_word(pack_time(23, 59, 59, 24, '1));
		send_word(64'h0);
		send_word('1);
		send_word(pack_time(0, 0, 0, 9, 64'h0));
		send_word(pack_time(0, 0, 59, 24, 64'hA5A5_A5A5_A5A5_A5A5));
		send_word(pack_time(0, 59, 59, 24, 64'h5A5A_5A5A_5A5A_5A5A));
		send_word(pack_time(9, 59, 59, 24, 64'h0));
		send_word(pack_time(19, 59, 59, 24, 64'h0));
		send_word(pack_time(25, 59, 59, 24, 64'h0));
		send_word(64'h0000_0000_0000_000F);
		send_word(64'h0000_0000_0000_010C);
		send_word(64'h0000_0000_0709_0224);
		send_word(pack_time(0, 69, 59, 24, 64'h0));
		drain_results();

		write_frame_system(1'b0);
		send_word(pack_time(0, 0, 0, 29, 64'h0));
		send_word(pack_time(23, 59, 59, 29, '1));
		send_word(64'h0000_0000_0000_0309);
		send_word(64'h0000_0000_0000_0305);
		send_word(64'h0);
		send_word('1);
		send_word(pack_time(12, 34, 56, 19, {$urandom, $urandom}));
		send_word(pack_time(0, 0, 59, 29, 64'h0));
		drain_results();

		random_phase(70, 1'b1);
		src_idle_pct = 67;
		sink_idle_pct = 32;
		random_phase(70, 1'b0);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		hold_req = 1'b1;
		random_phase(70, 1'($urandom_range(1)));

		$display("Covered %0d time code words: %0d in the 25 frame system, %0d in the 30 frame system.",
			book.words_25 + book.words_30, book.words_25, book.words_30);
		$display("Checked %0d RAM words under both idle patterns and a long output stall.",
			book.ram_words_seen);
		if (book.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
